// File: hdl/ekmt_pkg.sv
package ekmt_pkg;

    localparam int unsigned TableDepthDefault = 1024;
    localparam int unsigned KeyWidth = 31;
    localparam int unsigned CountWidth = 11;

    localparam logic FuncInsert = 1'b0;
    localparam logic FuncQuery  = 1'b1;

    typedef struct packed {
        logic [KeyWidth-1:0] run_number;
        logic [KeyWidth-1:0] section_number;
        logic [KeyWidth-1:0] event_number;
    } t_key;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic srch_init;
        logic rd_mid;
        logic step;
        logic rd_shift;
        logic wr_shift;
        logic put;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic full;
        logic srch_done;
        logic shift_done;
    } t_status;

endpackage

// File: hdl/event_key_membership_table_top.sv
// sorted key table with binary search. a request is taken when start is high and busy is low;
// its single result is shown for one cycle with o_valid and cannot be stalled. a lookup makes
// up to floor(log2(count))+1 binary search steps (none on an empty table). a query responds
// once its search ends; an insert then shifts up the entries above its place one at a time
// and writes the key. an insert on a full table is rejected with no search. reset empties the
// table at once, no clearing pass.
module event_key_membership_table_top #(
    parameter int unsigned TABLE_DEPTH = ekmt_pkg::TableDepthDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_run_number,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_section_number,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_event_number,
    output logic                             o_valid,
    output logic                             o_found,
    output logic                             o_rejected,
    output logic [ekmt_pkg::CountWidth-1:0]  o_entry_count
);

    ekmt_pkg::t_cmd    w_cmd;
    ekmt_pkg::t_status w_status;

    ekmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    ekmt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_func           (i_func),
        .i_run_number     (i_run_number),
        .i_section_number (i_section_number),
        .i_event_number   (i_event_number),
        .o_status         (w_status),
        .o_found          (o_found),
        .o_rejected       (o_rejected),
        .o_entry_count    (o_entry_count)
    );

endmodule

// File: hdl/ekmt_datapath.sv
module ekmt_datapath #(
    parameter int unsigned TABLE_DEPTH = ekmt_pkg::TableDepthDefault,
    localparam int unsigned AW = $clog2(TABLE_DEPTH),
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ekmt_pkg::t_cmd                   i_cmd,
    input  logic                             i_func,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_run_number,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_section_number,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_event_number,
    output ekmt_pkg::t_status                o_status,
    output logic                             o_found,
    output logic                             o_rejected,
    output logic [ekmt_pkg::CountWidth-1:0]  o_entry_count
);

    ekmt_pkg::t_key r_mem [TABLE_DEPTH];
    ekmt_pkg::t_key r_key;
    ekmt_pkg::t_key r_rd;
    logic           r_func;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_lo;
    logic [CW-1:0]  r_hi;
    logic [CW-1:0]  r_mid;
    logic [CW-1:0]  r_sp;
    logic [CW-1:0]  n_mid;
    logic [CW-1:0]  r_laddr;
    logic [AW-1:0]  w_raddr;
    logic           w_less;
    logic           w_eq;

    assign n_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_less = (r_rd < r_key);
    assign w_eq = (r_rd == r_key);
    // shift pointer: read sp-1, write sp
    assign w_raddr = i_cmd.rd_shift ? AW'(r_sp - CW'(1)) : AW'(n_mid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_mid || i_cmd.rd_shift) begin
            r_rd <= r_mem[w_raddr];
        end
        if (i_cmd.wr_shift) begin
            r_mem[AW'(r_sp)] <= r_rd;
        end else if (i_cmd.put) begin
            r_mem[AW'(r_lo)] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_found <= 1'b0;
            o_rejected <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.respond) begin
                o_found <= r_func && (r_lo < r_count) && r_laddr == r_lo;
                o_rejected <= !r_func && (r_count == CW'(TABLE_DEPTH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= '{i_run_number, i_section_number, i_event_number};
            r_func <= i_func;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
            r_sp <= r_count;
            r_laddr <= '1;
        end
        if (i_cmd.rd_mid) begin
            r_mid <= n_mid;
        end
        if (i_cmd.step) begin
            if (w_less || (!r_func && w_eq)) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
                if (w_eq) begin
                    r_laddr <= r_mid;
                end
            end
        end
        if (i_cmd.wr_shift) begin
            r_sp <= r_sp - CW'(1);
        end
    end

    // found: last equal probe is the lower bound
    assign o_status.is_query = r_func;
    assign o_status.full = (r_count == CW'(TABLE_DEPTH));
    assign o_status.srch_done = !(r_lo < r_hi);
    assign o_status.shift_done = (r_sp == r_lo);
    assign o_entry_count = ekmt_pkg::CountWidth'(r_count);

endmodule

// File: hdl/ekmt_ctrl.sv
module ekmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ekmt_pkg::t_status i_status,
    output ekmt_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    ekmt_pkg::t_state r_state;
    ekmt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ekmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ekmt_pkg::S_IDLE: begin
                if (i_start) n_state = ekmt_pkg::S_READ;
            end
            ekmt_pkg::S_READ: begin
                if (!i_status.is_query && i_status.full) begin
                    n_state = ekmt_pkg::S_DONE;
                end else if (i_status.srch_done) begin
                    n_state = i_status.is_query ? ekmt_pkg::S_DONE : ekmt_pkg::S_SHIFT_RD;
                end else begin
                    n_state = ekmt_pkg::S_CMP;
                end
            end
            ekmt_pkg::S_CMP: n_state = ekmt_pkg::S_READ;
            ekmt_pkg::S_SHIFT_RD: begin
                n_state = i_status.shift_done ? ekmt_pkg::S_PUT : ekmt_pkg::S_SHIFT_WR;
            end
            ekmt_pkg::S_SHIFT_WR: n_state = ekmt_pkg::S_SHIFT_RD;
            ekmt_pkg::S_PUT: n_state = ekmt_pkg::S_DONE;
            ekmt_pkg::S_DONE: n_state = ekmt_pkg::S_IDLE;
            default: n_state = ekmt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ekmt_pkg::S_IDLE: begin
                o_cmd.load = i_start;
                o_cmd.srch_init = i_start;
            end
            ekmt_pkg::S_READ: begin
                o_cmd.rd_mid = !i_status.srch_done;
                o_cmd.respond = (!i_status.is_query && i_status.full)
                    || (i_status.srch_done && i_status.is_query);
            end
            ekmt_pkg::S_CMP: o_cmd.step = 1'b1;
            ekmt_pkg::S_SHIFT_RD: o_cmd.rd_shift = !i_status.shift_done;
            ekmt_pkg::S_SHIFT_WR: o_cmd.wr_shift = 1'b1;
            ekmt_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
                o_cmd.respond = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ekmt_pkg::S_IDLE);
    assign o_valid = (r_state == ekmt_pkg::S_DONE);

endmodule

// File: tb/event_key_membership_table_checker.sv
`timescale 1ns / 1ps

module event_key_membership_table_checker #(
    parameter int unsigned TABLE_DEPTH = ekmt_pkg::TableDepthDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic                             i_func,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_run_number,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_section_number,
    input  logic [ekmt_pkg::KeyWidth-1:0]    i_event_number,
    input  logic                             i_valid,
    input  logic                             i_found,
    input  logic                             i_rejected,
    input  logic [ekmt_pkg::CountWidth-1:0]  i_entry_count,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_hit_count,
    output int                               o_reject_count
);

    typedef struct packed {
        logic                            found;
        logic                            rejected;
        logic [ekmt_pkg::CountWidth-1:0] entry_count;
    } t_answer;

    ekmt_pkg::t_key sorted_keys[$];
    t_answer        answers_due[$];

    // packed key compares lexicographically: run, then section, then event
    function automatic t_answer apply_request(input logic func, input ekmt_pkg::t_key key);
        t_answer ans;
        int      pos;
        ans = '0;
        if (func == ekmt_pkg::FuncInsert) begin
            if (sorted_keys.size() >= TABLE_DEPTH) begin
                ans.rejected = 1'b1;
            end else begin
                pos = 0;
                while (pos < sorted_keys.size() && sorted_keys[pos] <= key) pos++;
                sorted_keys.insert(pos, key);
            end
        end else begin
            foreach (sorted_keys[k]) if (sorted_keys[k] == key) ans.found = 1'b1;
        end
        ans.entry_count = ekmt_pkg::CountWidth'(sorted_keys.size());
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            sorted_keys.delete();
            answers_due.delete();
            o_fail_count   <= 0;
            o_pending      <= 0;
            o_hit_count    <= 0;
            o_reject_count <= 0;
        end else begin
            if (i_valid) begin
                if (answers_due.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %0d/%0d/%0d",
                             $time, i_found, i_rejected, i_entry_count);
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.found !== i_found) begin
                        $display("%0t found: expected %0d actual %0d", $time, want.found, i_found);
                        errs++;
                    end
                    if (want.rejected !== i_rejected) begin
                        $display("%0t rejected: expected %0d actual %0d",
                                 $time, want.rejected, i_rejected);
                        errs++;
                    end
                    if (want.entry_count !== i_entry_count) begin
                        $display("%0t entry_count: expected %0d actual %0d",
                                 $time, want.entry_count, i_entry_count);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                want = apply_request(i_func, '{i_run_number, i_section_number, i_event_number});
                answers_due = {answers_due, want};
                if (want.found) o_hit_count <= o_hit_count + 1;
                if (want.rejected) o_reject_count <= o_reject_count + 1;
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= answers_due.size();
        end
    end

endmodule

// File: tb/event_key_membership_table_top_tb.sv
`timescale 1ns / 1ps

module event_key_membership_table_top_tb;

    localparam int unsigned Depth = ekmt_pkg::TableDepthDefault;
    localparam int RandomRequests = 1325;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            i_func = ekmt_pkg::FuncInsert;
    logic [ekmt_pkg::KeyWidth-1:0]   i_run_number = '0;
    logic [ekmt_pkg::KeyWidth-1:0]   i_section_number = '0;
    logic [ekmt_pkg::KeyWidth-1:0]   i_event_number = '0;
    logic                            o_valid;
    logic                            o_found;
    logic                            o_rejected;
    logic [ekmt_pkg::CountWidth-1:0] o_entry_count;

    int   fail_count, pending, hit_count, reject_count;
    logic taken = 1'b0;
    int   burst_left = 0;
    int   request_total = 0;
    ekmt_pkg::t_key inserted_keys[$];
    logic [ekmt_pkg::KeyWidth-1:0] ascending_run = 31'h7000_0000;

    event_key_membership_table_top #(.TABLE_DEPTH(Depth)) dut (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_run_number, .i_section_number,
        .i_event_number, .o_valid, .o_found, .o_rejected, .o_entry_count
    );

    event_key_membership_table_checker #(.TABLE_DEPTH(Depth)) u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_func, .i_run_number,
        .i_section_number, .i_event_number, .i_valid(o_valid), .i_found(o_found),
        .i_rejected(o_rejected), .i_entry_count(o_entry_count),
        .o_fail_count(fail_count), .o_pending(pending), .o_hit_count(hit_count),
        .o_reject_count(reject_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) taken <= start && !busy;

    // bursts of back-to-back requests separated by random gaps
    task automatic send_request(input logic func, input ekmt_pkg::t_key key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start            = 1'b1;
        i_func           = func;
        i_run_number     = key.run_number;
        i_section_number = key.section_number;
        i_event_number   = key.event_number;
        @(negedge i_clk);
        while (!taken) @(negedge i_clk);
        if (func == ekmt_pkg::FuncInsert) inserted_keys = {inserted_keys, key};
        request_total++;
    endtask

    function automatic ekmt_pkg::t_key random_key();
        return '{ekmt_pkg::KeyWidth'($urandom()), ekmt_pkg::KeyWidth'($urandom()),
                 ekmt_pkg::KeyWidth'($urandom())};
    endfunction

    function automatic ekmt_pkg::t_key stored_pick();
        return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    endfunction

    initial begin
        ekmt_pkg::t_key key;
        int             sel;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, extremes, duplicates, near misses
        send_request(ekmt_pkg::FuncQuery, '{31'd0, 31'd0, 31'd0});
        send_request(ekmt_pkg::FuncInsert, '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff});
        send_request(ekmt_pkg::FuncInsert, '{31'd0, 31'd0, 31'd0});
        send_request(ekmt_pkg::FuncInsert, '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff});
        send_request(ekmt_pkg::FuncInsert, '{31'd0, 31'd0, 31'd0});
        send_request(ekmt_pkg::FuncQuery, '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff});
        send_request(ekmt_pkg::FuncQuery, '{31'd0, 31'd0, 31'd0});
        send_request(ekmt_pkg::FuncQuery, '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_fffe});
        send_request(ekmt_pkg::FuncQuery, '{31'd0, 31'd0, 31'd1});
        send_request(ekmt_pkg::FuncInsert, '{31'd5, 31'd7, 31'd9});
        send_request(ekmt_pkg::FuncInsert, '{31'd5, 31'd6, 31'h7fff_ffff});
        send_request(ekmt_pkg::FuncInsert, '{31'd4, 31'h7fff_ffff, 31'd0});
        send_request(ekmt_pkg::FuncInsert, '{31'd5, 31'd7, 31'd8});
        send_request(ekmt_pkg::FuncQuery, '{31'd5, 31'd7, 31'd9});
        send_request(ekmt_pkg::FuncQuery, '{31'd5, 31'd6, 31'h7fff_ffff});
        send_request(ekmt_pkg::FuncQuery, '{31'd4, 31'h7fff_ffff, 31'd0});
        send_request(ekmt_pkg::FuncQuery, '{31'd5, 31'd7, 31'd7});
        send_request(ekmt_pkg::FuncQuery, '{31'd5, 31'd8, 31'd9});
        send_request(ekmt_pkg::FuncQuery, '{31'd6, 31'd7, 31'd9});
        send_request(ekmt_pkg::FuncQuery, '{31'h2aaa_aaaa, 31'h5555_5555, 31'h2aaa_aaaa});

        // random: mostly ascending loads so shifts stay short, enough to fill the table
        repeat (RandomRequests) begin
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    ascending_run = ascending_run
                        + ekmt_pkg::KeyWidth'($urandom_range(0, 3));
                    key = '{ascending_run, ekmt_pkg::KeyWidth'($urandom_range(0, 15)),
                            ekmt_pkg::KeyWidth'($urandom())};
                end else if (sel < 85) begin
                    key = random_key();
                end else begin
                    key = stored_pick();
                end
                send_request(ekmt_pkg::FuncInsert, key);
            end else begin
                sel = $urandom_range(0, 3);
                key = (sel == 0) ? random_key() : stored_pick();
                if (sel == 1) key.event_number = key.event_number ^ 31'd1;
                send_request(ekmt_pkg::FuncQuery, key);
            end
        end
        start = 1'b0;

        wait (pending == 0);
        repeat (50) @(negedge i_clk);
        $display("requests sent: %0d, query hits: %0d, inserts rejected on full table: %0d",
                 request_total, hit_count, reject_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
